>>> rtl/core/orot_pkg.sv
// ============================================================================
// orot_pkg: shared types and constants for the oriented rectangle overlap test
// Holds the CORDIC arctangent table, the trig word type and the pipeline
// stage counts that the lanes and the top level agree on.
// ============================================================================
package orot_pkg;

    // CORDIC rotation: 24 iterations on 30 fraction bits.
    localparam int CORDIC_STEPS = 24;
    localparam int CX_W         = 34;   // x and y datapath width
    localparam int Z_W          = 33;   // residual angle width
    localparam int TRIG_W       = 18;   // cos and sin, 16 fraction bits
    localparam int TRIG_SHIFT   = 16;
    localparam int ROUND_SHIFT  = 14;   // 30 fraction bits down to 16

    localparam logic signed [CX_W-1:0] CORDIC_INV_GAIN = CX_W'(652032874);

    // Arctangent of 2^-i in units of 2^32 per turn.
    localparam logic signed [Z_W-1:0] ARC_TABLE [CORDIC_STEPS] = '{
        Z_W'(536870912), Z_W'(316933406), Z_W'(167458907), Z_W'(85004756),
        Z_W'(42667331),  Z_W'(21354465),  Z_W'(10679838),  Z_W'(5340245),
        Z_W'(2670163),   Z_W'(1335087),   Z_W'(667544),    Z_W'(333772),
        Z_W'(166886),    Z_W'(83443),     Z_W'(41722),     Z_W'(20861),
        Z_W'(10430),     Z_W'(5215),      Z_W'(2608),      Z_W'(1304),
        Z_W'(652),       Z_W'(326),       Z_W'(163),       Z_W'(81)
    };

    // Quadrant codes from the top two phase bits.
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;

    // Corner offset signs, bit k for corner k: offsets (-w,-h) (w,-h) (w,h) (-w,h).
    localparam logic [3:0] CORNER_W_NEG = 4'b1001;
    localparam logic [3:0] CORNER_H_NEG = 4'b0011;

    // Pipeline depth of each part.
    localparam int CORDIC_STAGES = CORDIC_STEPS + 2;
    localparam int CORNER_STAGES = 2;
    localparam int LANE_STAGES   = 5;
    localparam int TOTAL_STAGES  = CORDIC_STAGES + CORNER_STAGES + LANE_STAGES + 1;

    typedef struct packed {
        logic signed [TRIG_W-1:0] cos_v;
        logic signed [TRIG_W-1:0] sin_v;
    } trig_t;

endpackage

>>> rtl/core/orot_cordic.sv
// ============================================================================
// orot_cordic: pipelined CORDIC sine and cosine
// One iteration per stage on the first quadrant, then rounding to 16
// fraction bits and an exact quadrant turn.
// ============================================================================
module orot_cordic #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                                  aclk,
    input  logic [orot_pkg::CORDIC_STAGES-1:0]    en,
    input  logic [ANGLE_BITS-1:0]                 angle,
    output orot_pkg::trig_t                       trig
);
    localparam int N  = orot_pkg::CORDIC_STEPS;
    localparam int XW = orot_pkg::CX_W;
    localparam int ZW = orot_pkg::Z_W;
    localparam int TW = orot_pkg::TRIG_W;

    logic signed [XW-1:0] x_reg [N+1];
    logic signed [XW-1:0] y_reg [N+1];
    logic signed [ZW-1:0] z_reg [N+1];
    logic [1:0]           q_reg [N+1];
    orot_pkg::trig_t      trig_reg;
    orot_pkg::trig_t      trig_next;
    logic [29:0]          phase_low;
    logic signed [XW-1:0] c_full;
    logic signed [XW-1:0] s_full;
    logic signed [TW-1:0] c_r;
    logic signed [TW-1:0] s_r;

    assign phase_low = {angle[ANGLE_BITS-3:0], {(32-ANGLE_BITS){1'b0}}};

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            x_reg[0] <= orot_pkg::CORDIC_INV_GAIN;
            y_reg[0] <= '0;
            z_reg[0] <= $signed({{(ZW-30){1'b0}}, phase_low});
            q_reg[0] <= angle[ANGLE_BITS-1 -: 2];
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_iter
        always_ff @(posedge aclk) begin
            if (en[i+1]) begin
                if (!z_reg[i][ZW-1]) begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - orot_pkg::ARC_TABLE[i];
                end else begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + orot_pkg::ARC_TABLE[i];
                end
                q_reg[i+1] <= q_reg[i];
            end
        end
    end

    always_comb begin
        c_full = (x_reg[N] + XW'(1 << (orot_pkg::ROUND_SHIFT - 1))) >>> orot_pkg::ROUND_SHIFT;
        s_full = (y_reg[N] + XW'(1 << (orot_pkg::ROUND_SHIFT - 1))) >>> orot_pkg::ROUND_SHIFT;
        c_r    = c_full[TW-1:0];
        s_r    = s_full[TW-1:0];
        case (q_reg[N])
            orot_pkg::QUAD_0: begin
                trig_next.cos_v = c_r;
                trig_next.sin_v = s_r;
            end
            orot_pkg::QUAD_1: begin
                trig_next.cos_v = -s_r;
                trig_next.sin_v = c_r;
            end
            orot_pkg::QUAD_2: begin
                trig_next.cos_v = -c_r;
                trig_next.sin_v = -s_r;
            end
            default: begin
                trig_next.cos_v = s_r;
                trig_next.sin_v = -c_r;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en[N+1]) begin
            trig_reg <= trig_next;
        end
    end

    assign trig = trig_reg;

endmodule

>>> rtl/core/orot_corner.sv
// ============================================================================
// orot_corner: rotated corners of one rectangle
// Multiplies the half extents by cos and sin, then forms the four corners
// in doubled units around the center, rounded half up.
// ============================================================================
module orot_corner #(
    parameter int COORD_BITS = 24
) (
    input  logic                                   aclk,
    input  logic [orot_pkg::CORNER_STAGES-1:0]     en,
    input  logic signed [COORD_BITS-1:0]           x,
    input  logic signed [COORD_BITS-1:0]           y,
    input  logic [COORD_BITS-2:0]                  w,
    input  logic [COORD_BITS-2:0]                  h,
    input  orot_pkg::trig_t                        trig,
    output logic signed [COORD_BITS+2:0]           px [4],
    output logic signed [COORD_BITS+2:0]           py [4],
    output orot_pkg::trig_t                        trig_out,
    output logic                                   has_w,
    output logic                                   has_h
);
    localparam int TW = orot_pkg::TRIG_W;
    localparam int MW = COORD_BITS + TW;     // extent times trig
    localparam int RW = MW + 1;              // sum of two products
    localparam int CW = COORD_BITS + 2;      // doubled center
    localparam int PW = COORD_BITS + 3;      // corner coordinate

    logic signed [MW-1:0] wc_reg, ws_reg, hc_reg, hs_reg;
    logic signed [CW-1:0] cx_reg, cy_reg;
    logic                 hw_reg, hh_reg, hw2_reg, hh2_reg;
    orot_pkg::trig_t      trig1_reg, trig2_reg;
    logic signed [PW-1:0] px_reg [4];
    logic signed [PW-1:0] py_reg [4];
    logic signed [COORD_BITS-1:0] w_s, h_s;

    assign w_s = $signed({1'b0, w});
    assign h_s = $signed({1'b0, h});

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            wc_reg    <= w_s * trig.cos_v;
            ws_reg    <= w_s * trig.sin_v;
            hc_reg    <= h_s * trig.cos_v;
            hs_reg    <= h_s * trig.sin_v;
            cx_reg    <= $signed({x[COORD_BITS-1], x, 1'b0}) + $signed({3'b000, w});
            cy_reg    <= $signed({y[COORD_BITS-1], y, 1'b0}) + $signed({3'b000, h});
            hw_reg    <= (w != '0);
            hh_reg    <= (h != '0);
            trig1_reg <= trig;
        end
        if (en[1]) begin
            hw2_reg   <= hw_reg;
            hh2_reg   <= hh_reg;
            trig2_reg <= trig1_reg;
        end
    end

    for (genvar k = 0; k < 4; k++) begin : g_corner
        logic signed [RW-1:0] rx, ry, rxh, ryh;
        always_comb begin
            rx  = (orot_pkg::CORNER_W_NEG[k] ? -RW'(wc_reg) : RW'(wc_reg))
                + (orot_pkg::CORNER_H_NEG[k] ?  RW'(hs_reg) : -RW'(hs_reg));
            ry  = (orot_pkg::CORNER_W_NEG[k] ? -RW'(ws_reg) : RW'(ws_reg))
                + (orot_pkg::CORNER_H_NEG[k] ? -RW'(hc_reg) : RW'(hc_reg));
            rxh = rx + RW'(1 << (orot_pkg::TRIG_SHIFT - 1));
            ryh = ry + RW'(1 << (orot_pkg::TRIG_SHIFT - 1));
        end
        always_ff @(posedge aclk) begin
            if (en[1]) begin
                px_reg[k] <= PW'(cx_reg) + $signed(rxh[RW-1:orot_pkg::TRIG_SHIFT]);
                py_reg[k] <= PW'(cy_reg) + $signed(ryh[RW-1:orot_pkg::TRIG_SHIFT]);
            end
        end
        assign px[k] = px_reg[k];
        assign py[k] = py_reg[k];
    end

    assign trig_out = trig2_reg;
    assign has_w    = hw2_reg;
    assign has_h    = hh2_reg;

endmodule

>>> rtl/core/orot_lane.sv
// ============================================================================
// orot_lane: projection of both rectangles onto one axis
// Projects all eight corners, reduces each rectangle to its interval and
// flags the axis when it is on and the intervals are strictly apart.
// ============================================================================
module orot_lane #(
    parameter int COORD_BITS = 24
) (
    input  logic                                 aclk,
    input  logic [orot_pkg::LANE_STAGES-1:0]     en,
    input  logic signed [orot_pkg::TRIG_W-1:0]   ax,
    input  logic signed [orot_pkg::TRIG_W-1:0]   ay,
    input  logic                                 axis_on,
    input  logic signed [COORD_BITS+2:0]         ax_px [4],
    input  logic signed [COORD_BITS+2:0]         ax_py [4],
    input  logic signed [COORD_BITS+2:0]         bx_px [4],
    input  logic signed [COORD_BITS+2:0]         bx_py [4],
    output logic                                 sep
);
    localparam int PW  = COORD_BITS + 3;
    localparam int PRW = PW + orot_pkg::TRIG_W;
    localparam int DW  = PRW + 1;

    logic signed [PRW-1:0] pa_reg [8];
    logic signed [PRW-1:0] pb_reg [8];
    logic signed [DW-1:0]  d_reg  [8];
    logic signed [DW-1:0]  lo2_reg [4];
    logic signed [DW-1:0]  hi2_reg [4];
    logic signed [DW-1:0]  lo_reg [2];
    logic signed [DW-1:0]  hi_reg [2];
    logic [3:0]            on_reg;
    logic                  sep_reg;

    for (genvar k = 0; k < 4; k++) begin : g_proj
        always_ff @(posedge aclk) begin
            if (en[0]) begin
                pa_reg[k]   <= ax_px[k] * ax;
                pb_reg[k]   <= ax_py[k] * ay;
                pa_reg[k+4] <= bx_px[k] * ax;
                pb_reg[k+4] <= bx_py[k] * ay;
            end
        end
    end

    for (genvar k = 0; k < 8; k++) begin : g_sum
        always_ff @(posedge aclk) begin
            if (en[1]) begin
                d_reg[k] <= DW'(pa_reg[k]) + DW'(pb_reg[k]);
            end
        end
    end

    for (genvar p = 0; p < 4; p++) begin : g_pair
        always_ff @(posedge aclk) begin
            if (en[2]) begin
                lo2_reg[p] <= (d_reg[2*p] < d_reg[2*p+1]) ? d_reg[2*p] : d_reg[2*p+1];
                hi2_reg[p] <= (d_reg[2*p] > d_reg[2*p+1]) ? d_reg[2*p] : d_reg[2*p+1];
            end
        end
    end

    for (genvar r = 0; r < 2; r++) begin : g_rect
        always_ff @(posedge aclk) begin
            if (en[3]) begin
                lo_reg[r] <= (lo2_reg[2*r] < lo2_reg[2*r+1]) ? lo2_reg[2*r] : lo2_reg[2*r+1];
                hi_reg[r] <= (hi2_reg[2*r] > hi2_reg[2*r+1]) ? hi2_reg[2*r] : hi2_reg[2*r+1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) on_reg[0] <= axis_on;
        if (en[1]) on_reg[1] <= on_reg[0];
        if (en[2]) on_reg[2] <= on_reg[1];
        if (en[3]) on_reg[3] <= on_reg[2];
        if (en[4]) begin
            sep_reg <= on_reg[3] && ((hi_reg[0] < lo_reg[1]) || (hi_reg[1] < lo_reg[0]));
        end
    end

    assign sep = sep_reg;

endmodule

>>> rtl/core/oriented_rectangle_overlap_test_core.sv
// ============================================================================
// oriented_rectangle_overlap_test_core: separating axis test for two rectangles
// Fully pipelined: one rectangle pair per cycle while m_ready does not hold
// the output; the CORDIC does one iteration per stage.
// Reset (aresetn, synchronous, active low) clears only the stage valid bits.
// The result of each pair is one overlap bit; touching counts as overlap.
// ============================================================================
module oriented_rectangle_overlap_test_core #(
    parameter int COORD_BITS = 24,
    parameter int ANGLE_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [COORD_BITS-1:0]  s_first_x,
    input  logic signed [COORD_BITS-1:0]  s_first_y,
    input  logic [COORD_BITS-2:0]         s_first_width,
    input  logic [COORD_BITS-2:0]         s_first_height,
    input  logic [ANGLE_BITS-1:0]         s_first_angle,
    input  logic signed [COORD_BITS-1:0]  s_second_x,
    input  logic signed [COORD_BITS-1:0]  s_second_y,
    input  logic [COORD_BITS-2:0]         s_second_width,
    input  logic [COORD_BITS-2:0]         s_second_height,
    input  logic [ANGLE_BITS-1:0]         s_second_angle,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_overlap
);
    localparam int NS  = orot_pkg::TOTAL_STAGES;
    localparam int CS  = orot_pkg::CORDIC_STAGES;
    localparam int KS  = orot_pkg::CORNER_STAGES;
    localparam int LS  = orot_pkg::LANE_STAGES;
    localparam int K0  = CS;            // first corner stage
    localparam int L0  = CS + KS;       // first lane stage
    localparam int M0  = CS + KS + LS;  // merge and output register
    localparam int PW  = COORD_BITS + 3;

    // Each stage holds a valid bit. A stage loads when it is empty or when
    // the stage after it loads, so bubbles collapse and the pipeline keeps
    // taking transfers into empty stages while the output register waits on m_ready.
    logic [NS-1:0] v_reg;
    logic [NS:0]   en;

    assign en[NS] = m_ready;
    for (genvar k = 0; k < NS; k++) begin : g_en
        assign en[k] = !v_reg[k] || en[k+1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[0]) v_reg[0] <= s_valid;
            for (int k = 1; k < NS; k++) begin
                if (en[k]) v_reg[k] <= v_reg[k-1];
            end
        end
    end

    assign s_ready = en[0];
    assign m_valid = v_reg[NS-1];

    // Position and extent ride alongside the CORDIC stages so that they
    // meet the matching cos and sin at the corner stage.
    logic signed [COORD_BITS-1:0] x_d [2][CS];
    logic signed [COORD_BITS-1:0] y_d [2][CS];
    logic [COORD_BITS-2:0]        w_d [2][CS];
    logic [COORD_BITS-2:0]        h_d [2][CS];

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            x_d[0][0] <= s_first_x;
            y_d[0][0] <= s_first_y;
            w_d[0][0] <= s_first_width;
            h_d[0][0] <= s_first_height;
            x_d[1][0] <= s_second_x;
            y_d[1][0] <= s_second_y;
            w_d[1][0] <= s_second_width;
            h_d[1][0] <= s_second_height;
        end
        for (int k = 1; k < CS; k++) begin
            if (en[k]) begin
                for (int r = 0; r < 2; r++) begin
                    x_d[r][k] <= x_d[r][k-1];
                    y_d[r][k] <= y_d[r][k-1];
                    w_d[r][k] <= w_d[r][k-1];
                    h_d[r][k] <= h_d[r][k-1];
                end
            end
        end
    end

    // Per-rectangle trig and corner units.
    orot_pkg::trig_t      trig  [2];
    orot_pkg::trig_t      trig2 [2];
    logic signed [PW-1:0] px [2][4];
    logic signed [PW-1:0] py [2][4];
    logic                 has_w [2];
    logic                 has_h [2];
    logic [ANGLE_BITS-1:0] angle_in [2];

    assign angle_in[0] = s_first_angle;
    assign angle_in[1] = s_second_angle;

    for (genvar r = 0; r < 2; r++) begin : g_rect
        orot_cordic #(
            .ANGLE_BITS (ANGLE_BITS)
        ) u_cordic (
            .aclk  (aclk),
            .en    (en[CS-1:0]),
            .angle (angle_in[r]),
            .trig  (trig[r])
        );

        orot_corner #(
            .COORD_BITS (COORD_BITS)
        ) u_corner (
            .aclk     (aclk),
            .en       (en[K0+KS-1:K0]),
            .x        (x_d[r][CS-1]),
            .y        (y_d[r][CS-1]),
            .w        (w_d[r][CS-1]),
            .h        (h_d[r][CS-1]),
            .trig     (trig[r]),
            .px       (px[r]),
            .py       (py[r]),
            .trig_out (trig2[r]),
            .has_w    (has_w[r]),
            .has_h    (has_h[r])
        );
    end

    // Four axis lanes: for each rectangle the normal (-sin, cos) of its
    // width edges and (cos, sin) of its height edges. A zero-length edge
    // gives no axis, so its lane never reports separation.
    logic [3:0] sep;

    for (genvar r = 0; r < 2; r++) begin : g_axes
        orot_lane #(
            .COORD_BITS (COORD_BITS)
        ) u_lane_w (
            .aclk    (aclk),
            .en      (en[L0+LS-1:L0]),
            .ax      (-trig2[r].sin_v),
            .ay      (trig2[r].cos_v),
            .axis_on (has_w[r]),
            .ax_px   (px[0]),
            .ax_py   (py[0]),
            .bx_px   (px[1]),
            .bx_py   (py[1]),
            .sep     (sep[2*r])
        );

        orot_lane #(
            .COORD_BITS (COORD_BITS)
        ) u_lane_h (
            .aclk    (aclk),
            .en      (en[L0+LS-1:L0]),
            .ax      (trig2[r].cos_v),
            .ay      (trig2[r].sin_v),
            .axis_on (has_h[r]),
            .ax_px   (px[0]),
            .ax_py   (py[0]),
            .bx_px   (px[1]),
            .bx_py   (py[1]),
            .sep     (sep[2*r+1])
        );
    end

    // Merge: the rectangles overlap unless some lane found a separating axis.
    logic overlap_reg;

    always_ff @(posedge aclk) begin
        if (en[M0]) begin
            overlap_reg <= !(|sep);
        end
    end

    assign m_overlap = overlap_reg;

endmodule
